// ===== hdl/dcad_pkg.sv =====
// Shared constants and shared-unit types for the delta copy/add decoder.
package dcad_pkg;

    localparam int OLD_DEPTH = 4096;
    localparam int ADDR_W    = $clog2(OLD_DEPTH);
    localparam int SIZE_W    = $clog2(OLD_DEPTH + 1);
    localparam int LEN_W     = 16;
    localparam int OFF_W     = 13;
    localparam int ALU_W     = LEN_W + 1;
    localparam int MAX_COPY  = 63;
    localparam int CNT_W     = $clog2(MAX_COPY + 1);

    typedef enum logic {
        ALU_ADD,
        ALU_MAC10
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [LEN_W-1:0] a;
        logic [LEN_W-1:0] b;
        logic [LEN_W-1:0] limit;
    } alu_req_t;

endpackage

// ===== hdl/delta_copy_add_decoder.sv =====
// Delta copy/add decoder: old-file store, delta parser and copy sequencer.
//
// Loads append old-file bytes to a 4096-byte store; delta bytes rebuild the new
// file from "A<len>:" literal runs and "C<len>,<off>" copies. A copy passes a
// check step, then for each emitted byte a read step on the store's registered
// read port, with the address formed by the single shared adder, and an emit
// step, then a closing step; a copy ended by a delta byte then parses that byte
// in a tail step. Every step after the accept cycle, bar the read and closing
// steps, waits while the output register holds a result not yet taken. s_tready
// is low while a request is being worked on; results leave through a one-deep
// output register, so a request can be taken while the last result waits.
module delta_copy_add_decoder
    import dcad_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] byte_value
    input  logic [1:0] s_tuser,   // [1:0] command
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [1:0] status
    output logic       m_tlast
);

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_DELTA = 2'd1;
    localparam logic [1:0] CMD_END   = 2'd2;

    localparam logic [1:0] ST_DATA      = 2'd0;
    localparam logic [1:0] ST_FINISHED  = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    typedef enum logic [2:0] {
        S_IDLE, S_DELTA, S_END, S_FIN, S_CHECK, S_CPY_RD, S_CPY_EMIT, S_TAIL
    } state_t;

    typedef enum logic [2:0] {
        P_CMD_NL, P_CMD, P_A_FIRST, P_A_MORE, P_C_FIRST, P_C_MORE, P_OFF_FIRST, P_OFF_MORE
    } parse_t;

    state_t           state_reg, state_next;
    parse_t           parse_reg, parse_next;
    logic [7:0]       byte_reg, byte_next;
    logic [SIZE_W-1:0] old_size_reg, old_size_next;
    logic [LEN_W-1:0] length_reg, length_next;
    logic [OFF_W-1:0] offset_reg, offset_next;
    logic [LEN_W-1:0] literal_reg, literal_next;
    logic             error_reg, error_next;
    logic             tail_fin_reg, tail_fin_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_data_reg, m_data_next;
    logic [1:0]       m_user_reg, m_user_next;
    logic             m_last_reg, m_last_next;

    logic [7:0]        old_store [OLD_DEPTH];
    logic [7:0]        rd_data_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;

    alu_req_t         alu_req;
    logic [ALU_W-1:0] alu_y;

    logic       s_accept, out_free, is_digit, cmd_bad;
    logic [3:0] digit;
    logic       emit, emit_last, do_start, nl_ok, set_flag;
    logic [7:0] emit_byte;
    logic [1:0] emit_status;

    dcad_alu u_alu (
        .req (alu_req),
        .y   (alu_y)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    assign is_digit = (byte_reg >= CH_0) && (byte_reg <= CH_9);
    assign digit    = 4'(byte_reg - CH_0);
    assign cmd_bad  = !((byte_reg == CH_NL) || (byte_reg == CH_A) || (byte_reg == CH_C));
    assign wr_en    = s_accept && (s_tuser == CMD_LOAD) && (old_size_reg < SIZE_W'(OLD_DEPTH));
    assign rd_addr  = alu_y[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            old_store[old_size_reg[ADDR_W-1:0]] <= s_tdata;
        end
        if (rd_en) begin
            rd_data_reg <= old_store[rd_addr];
        end
    end

    always_comb begin
        alu_req.op    = ALU_ADD;
        alu_req.a     = LEN_W'(offset_reg);
        alu_req.b     = LEN_W'(cnt_reg);
        alu_req.limit = {LEN_W{1'b1}};
        case (state_reg)
            S_DELTA: begin
                alu_req.op = ALU_MAC10;
                alu_req.b  = LEN_W'(digit);
                if (parse_reg == P_OFF_MORE) begin
                    alu_req.a     = LEN_W'(offset_reg);
                    alu_req.limit = LEN_W'({OFF_W{1'b1}});
                end else begin
                    alu_req.a = length_reg;
                end
            end
            S_CHECK: begin
                alu_req.a = length_reg;
                alu_req.b = LEN_W'(offset_reg);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        parse_next    = parse_reg;
        byte_next     = byte_reg;
        old_size_next = old_size_reg;
        length_next   = length_reg;
        offset_next   = offset_reg;
        literal_next  = literal_reg;
        error_next    = error_reg;
        tail_fin_next = tail_fin_reg;
        cnt_next      = cnt_reg;
        rd_en         = 1'b0;
        emit          = 1'b0;
        emit_byte     = 8'h00;
        emit_status   = ST_DATA;
        emit_last     = 1'b0;
        do_start      = 1'b0;
        nl_ok         = 1'b0;
        set_flag      = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    byte_next = s_tdata;
                    case (s_tuser)
                        CMD_LOAD: begin
                            if (wr_en) begin
                                old_size_next = old_size_reg + 1'b1;
                            end
                        end
                        CMD_DELTA: begin
                            if (!error_reg) begin
                                state_next = S_DELTA;
                            end
                        end
                        CMD_END: begin
                            state_next = S_END;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DELTA: begin
                if (out_free) begin
                    state_next = S_IDLE;
                    if (literal_reg != '0) begin
                        emit         = 1'b1;
                        emit_byte    = byte_reg;
                        emit_last    = 1'b1;
                        literal_next = literal_reg - 1'b1;
                    end else begin
                        case (parse_reg)
                            P_CMD_NL: begin
                                do_start = 1'b1;
                                nl_ok    = 1'b1;
                            end
                            P_CMD: begin
                                do_start = 1'b1;
                            end
                            P_A_FIRST, P_C_FIRST: begin
                                if (is_digit) begin
                                    length_next = LEN_W'(digit);
                                    parse_next  = (parse_reg == P_A_FIRST) ? P_A_MORE : P_C_MORE;
                                end else begin
                                    set_flag = 1'b1;
                                end
                            end
                            P_A_MORE: begin
                                if (is_digit) begin
                                    length_next = alu_y[LEN_W-1:0];
                                end else if (byte_reg == CH_COLON) begin
                                    literal_next = length_reg;
                                    parse_next   = P_CMD_NL;
                                end else begin
                                    set_flag = 1'b1;
                                end
                            end
                            P_C_MORE: begin
                                if (is_digit) begin
                                    length_next = alu_y[LEN_W-1:0];
                                end else if (byte_reg == CH_COMMA) begin
                                    offset_next = '0;
                                    parse_next  = P_OFF_FIRST;
                                end else begin
                                    set_flag = 1'b1;
                                end
                            end
                            P_OFF_FIRST: begin
                                if (is_digit) begin
                                    offset_next = OFF_W'(digit);
                                    parse_next  = P_OFF_MORE;
                                end else begin
                                    set_flag = 1'b1;
                                end
                            end
                            default: begin
                                if (is_digit) begin
                                    offset_next = alu_y[OFF_W-1:0];
                                end else begin
                                    tail_fin_next = 1'b0;
                                    state_next    = S_CHECK;
                                end
                            end
                        endcase
                    end
                end
            end
            S_END: begin
                if (out_free) begin
                    state_next = S_FIN;
                    if (!error_reg) begin
                        if (literal_reg != '0) begin
                            emit        = 1'b1;
                            emit_status = ST_MALFORMED;
                        end else if (parse_reg == P_OFF_MORE) begin
                            tail_fin_next = 1'b1;
                            state_next    = S_CHECK;
                        end else if (parse_reg != P_CMD_NL && parse_reg != P_CMD) begin
                            emit        = 1'b1;
                            emit_status = ST_MALFORMED;
                        end
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    emit         = 1'b1;
                    emit_status  = ST_FINISHED;
                    emit_last    = 1'b1;
                    parse_next   = P_CMD_NL;
                    length_next  = '0;
                    offset_next  = '0;
                    literal_next = '0;
                    error_next   = 1'b0;
                    state_next   = S_IDLE;
                end
            end
            S_CHECK: begin
                if (out_free) begin
                    cnt_next = '0;
                    if (length_reg > LEN_W'(MAX_COPY)) begin
                        emit        = 1'b1;
                        emit_status = ST_MALFORMED;
                    end else if (alu_y > ALU_W'(old_size_reg)) begin
                        emit        = 1'b1;
                        emit_status = ST_RANGE;
                    end else begin
                        state_next = S_CPY_RD;
                    end
                    if (emit) begin
                        emit_last  = !tail_fin_reg;
                        error_next = 1'b1;
                        state_next = tail_fin_reg ? S_FIN : S_IDLE;
                    end
                end
            end
            S_CPY_RD: begin
                if (cnt_reg == length_reg[CNT_W-1:0]) begin
                    state_next = tail_fin_reg ? S_FIN : S_TAIL;
                end else begin
                    rd_en      = 1'b1;
                    state_next = S_CPY_EMIT;
                end
            end
            S_CPY_EMIT: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_byte  = rd_data_reg;
                    emit_last  = !tail_fin_reg && cmd_bad
                                 ? 1'b0
                                 : (!tail_fin_reg
                                    && (CNT_W'(cnt_reg + 1'b1) == length_reg[CNT_W-1:0]));
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_CPY_RD;
                end
            end
            S_TAIL: begin
                if (out_free) begin
                    parse_next = P_CMD_NL;
                    do_start   = 1'b1;
                    nl_ok      = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (do_start) begin
            if (byte_reg == CH_NL && nl_ok) begin
                parse_next = P_CMD;
            end else if (byte_reg == CH_A) begin
                length_next = '0;
                parse_next  = P_A_FIRST;
            end else if (byte_reg == CH_C) begin
                length_next = '0;
                parse_next  = P_C_FIRST;
            end else begin
                set_flag = 1'b1;
            end
        end

        if (set_flag) begin
            emit        = 1'b1;
            emit_status = ST_MALFORMED;
            emit_last   = 1'b1;
        end
        if (emit && emit_status == ST_MALFORMED) begin
            error_next = 1'b1;
        end

        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = emit_byte;
            m_user_next  = emit_status;
            m_last_next  = emit_last;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            parse_reg    <= P_CMD_NL;
            old_size_reg <= '0;
            length_reg   <= '0;
            offset_reg   <= '0;
            literal_reg  <= '0;
            error_reg    <= 1'b0;
            tail_fin_reg <= 1'b0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            parse_reg    <= parse_next;
            old_size_reg <= old_size_next;
            length_reg   <= length_next;
            offset_reg   <= offset_next;
            literal_reg  <= literal_next;
            error_reg    <= error_next;
            tail_fin_reg <= tail_fin_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
        end
        byte_reg   <= byte_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

endmodule

// ===== hdl/dcad_alu.sv =====
// Shared arithmetic unit: plain add, or decimal accumulate a*10+b saturating at a limit.
module dcad_alu
    import dcad_pkg::*;
(
    input  alu_req_t          req,
    output logic [ALU_W-1:0]  y
);

    logic [LEN_W+3:0] mac;

    always_comb begin
        mac = {req.a, 3'b000} + {2'b00, req.a, 1'b0} + {4'b0000, req.b};
        case (req.op)
            ALU_MAC10: begin
                if (mac > {4'b0000, req.limit}) begin
                    y = {1'b0, req.limit};
                end else begin
                    y = mac[ALU_W-1:0];
                end
            end
            default: begin
                y = {1'b0, req.a} + {1'b0, req.b};
            end
        endcase
    end

endmodule

// ===== dv/dcad_tb_pkg.sv =====
// Request kinds, result status codes and delta syntax bytes shared by the verification files.
`timescale 1ns / 1ps
package dcad_tb_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_DELTA = 2'd1,
        CMD_END   = 2'd2,
        CMD_SPARE = 2'd3
    } dcad_cmd_t;

    typedef enum logic [1:0] {
        ST_DATA      = 2'd0,
        ST_FINISHED  = 2'd1,
        ST_MALFORMED = 2'd2,
        ST_RANGE     = 2'd3
    } dcad_status_t;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ADD   = 8'h41;
    localparam logic [7:0] CH_COPY  = 8'h43;

endpackage

// ===== dv/dcad_checker.sv =====
// Channel monitor that predicts the rebuilt byte stream and compares every result.
`timescale 1ns / 1ps
module dcad_checker
    import dcad_pkg::*;
    import dcad_tb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic [1:0] s_tuser,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic [1:0] m_tuser,
    input  logic       m_tlast,
    output int         mismatches,
    output int         outstanding,
    output int         results_checked
);

    typedef enum logic [2:0] {
        PS_CMD,
        PS_CMD_NL,
        PS_ALEN_FIRST,
        PS_ALEN,
        PS_CLEN_FIRST,
        PS_CLEN,
        PS_OFF_FIRST,
        PS_OFF
    } parse_t;

    typedef struct packed {
        logic [7:0]   data;
        dcad_status_t status;
        logic         last;
    } result_t;

    result_t           new_file_q[$];
    logic [7:0]        old_mem [OLD_DEPTH];
    logic [SIZE_W-1:0] old_fill;
    parse_t            pstate;
    logic [LEN_W-1:0]  len_acc;
    logic [OFF_W-1:0]  off_acc;
    logic [LEN_W-1:0]  lit_left;
    logic              err_seen;
    int                req_results;
    int                fail_count;
    int                compared;

    function automatic bit is_digit(logic [7:0] b);
        return b >= CH_0 && b <= CH_9;
    endfunction

    function automatic int mac10(int acc, logic [7:0] b, int limit);
        int v;
        v = acc * 10 + int'(b - CH_0);
        return (v > limit) ? limit : v;
    endfunction

    function automatic void push_byte(logic [7:0] b, dcad_status_t st);
        result_t r;
        r.data   = b;
        r.status = st;
        r.last   = 1'b0;
        new_file_q.push_back(r);
        req_results++;
    endfunction

    function automatic void raise(dcad_status_t st);
        push_byte(8'h00, st);
        err_seen = 1'b1;
    endfunction

    function automatic bit copy_run();
        int idx;
        if (len_acc > MAX_COPY) begin
            raise(ST_MALFORMED);
            return 1'b0;
        end
        if (int'(off_acc) + int'(len_acc) > int'(old_fill)) begin
            raise(ST_RANGE);
            return 1'b0;
        end
        for (int i = 0; i < int'(len_acc); i++) begin
            idx = int'(off_acc) + i;
            push_byte(old_mem[ADDR_W'(idx)], ST_DATA);
        end
        return 1'b1;
    endfunction

    function automatic void open_command(logic [7:0] b, bit nl_ok);
        if (b == CH_NL && nl_ok) begin
            pstate = PS_CMD_NL;
        end else if (b == CH_ADD) begin
            len_acc = '0;
            pstate  = PS_ALEN_FIRST;
        end else if (b == CH_COPY) begin
            len_acc = '0;
            pstate  = PS_CLEN_FIRST;
        end else begin
            raise(ST_MALFORMED);
        end
    endfunction

    function automatic void parse_delta(logic [7:0] b);
        if (err_seen) return;
        if (lit_left != 0) begin
            push_byte(b, ST_DATA);
            lit_left--;
            return;
        end
        case (pstate)
            PS_CMD:    open_command(b, 1'b1);
            PS_CMD_NL: open_command(b, 1'b0);
            PS_ALEN_FIRST, PS_CLEN_FIRST: begin
                if (is_digit(b)) begin
                    len_acc = LEN_W'(b - CH_0);
                    pstate  = (pstate == PS_ALEN_FIRST) ? PS_ALEN : PS_CLEN;
                end else begin
                    raise(ST_MALFORMED);
                end
            end
            PS_ALEN: begin
                if (is_digit(b)) begin
                    len_acc = LEN_W'(mac10(int'(len_acc), b, (1 << LEN_W) - 1));
                end else if (b == CH_COLON) begin
                    lit_left = len_acc;
                    pstate   = PS_CMD;
                end else begin
                    raise(ST_MALFORMED);
                end
            end
            PS_CLEN: begin
                if (is_digit(b)) begin
                    len_acc = LEN_W'(mac10(int'(len_acc), b, (1 << LEN_W) - 1));
                end else if (b == CH_COMMA) begin
                    off_acc = '0;
                    pstate  = PS_OFF_FIRST;
                end else begin
                    raise(ST_MALFORMED);
                end
            end
            PS_OFF_FIRST: begin
                if (is_digit(b)) begin
                    off_acc = OFF_W'(b - CH_0);
                    pstate  = PS_OFF;
                end else begin
                    raise(ST_MALFORMED);
                end
            end
            default: begin
                if (is_digit(b)) begin
                    off_acc = OFF_W'(mac10(int'(off_acc), b, (1 << OFF_W) - 1));
                end else if (copy_run()) begin
                    pstate = PS_CMD;
                    open_command(b, 1'b1);
                end
            end
        endcase
    endfunction

    function automatic void clear_parser();
        pstate   = PS_CMD;
        len_acc  = '0;
        off_acc  = '0;
        lit_left = '0;
        err_seen = 1'b0;
    endfunction

    function automatic void decode_request(logic [1:0] cmd, logic [7:0] b);
        result_t r;
        req_results = 0;
        case (cmd)
            CMD_LOAD: begin
                if (old_fill < OLD_DEPTH) begin
                    old_mem[old_fill[ADDR_W-1:0]] = b;
                    old_fill++;
                end
            end
            CMD_DELTA: parse_delta(b);
            CMD_END: begin
                if (!err_seen) begin
                    if (lit_left != 0)
                        raise(ST_MALFORMED);
                    else if (pstate == PS_OFF)
                        void'(copy_run());
                    else if (pstate != PS_CMD && pstate != PS_CMD_NL)
                        raise(ST_MALFORMED);
                end
                push_byte(8'h00, ST_FINISHED);
                clear_parser();
            end
            default: ;
        endcase
        if (req_results > 0) begin
            r = new_file_q.pop_back();
            r.last = 1'b1;
            new_file_q.push_back(r);
        end
    endfunction

    always @(posedge aclk) begin
        result_t exp_r;
        if (!aresetn) begin
            new_file_q.delete();
            old_fill   = '0;
            fail_count = 0;
            compared   = 0;
            clear_parser();
        end else begin
            if (s_tvalid && s_tready)
                decode_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (new_file_q.size() == 0) begin
                    $error("result with none expected: out_byte 0x%02h status %0d last %0b",
                           m_tdata, m_tuser, m_tlast);
                    fail_count++;
                end else begin
                    exp_r = new_file_q.pop_front();
                    compared++;
                    if (m_tdata !== exp_r.data) begin
                        $error("out_byte: expected 0x%02h, got 0x%02h", exp_r.data, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser !== exp_r.status) begin
                        $error("status: expected %0d, got %0d", exp_r.status, m_tuser);
                        fail_count++;
                    end
                    if (m_tlast !== exp_r.last) begin
                        $error("last: expected %0b, got %0b", exp_r.last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
        mismatches      <= fail_count;
        outstanding     <= new_file_q.size();
        results_checked <= compared;
    end

endmodule

// ===== dv/delta_copy_add_decoder_tb.sv =====
// Top-level bench: clock, reset, delta stream stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module delta_copy_add_decoder_tb;
    import dcad_pkg::*;
    import dcad_tb_pkg::*;

    localparam int RANDOM_ITEMS   = 300;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 100;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic [1:0] s_tuser  = 2'b00;
    logic       m_tready = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    int mismatches;
    int outstanding;
    int results_checked;
    int quiet_cycles;
    bit idle_en   = 1'b1;
    bit effective = 1'b1;
    int old_bytes;
    int rand_items;
    int n_load, n_delta, n_end, n_copy, n_literal, n_fault;

    always #4 aclk = ~aclk;

    delta_copy_add_decoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    dcad_checker u_chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    // result side back-pressure
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && idle_en && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send(input dcad_cmd_t c, input logic [7:0] b);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        case (c)
            CMD_LOAD: begin
                n_load++;
                if (old_bytes < OLD_DEPTH) old_bytes++;
            end
            CMD_DELTA: n_delta++;
            CMD_END:   n_end++;
            default: ;
        endcase
        if (effective) rand_items++;
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++) send(CMD_DELTA, t[i]);
    endtask

    task automatic send_literal(input int n);
        for (int i = 0; i < n; i++) send(CMD_DELTA, 8'($urandom_range(0, 255)));
    endtask

    task automatic load_random(input int n);
        for (int i = 0; i < n; i++) send(CMD_LOAD, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_noise(input int n);
        effective = 1'b0;
        for (int i = 0; i < n; i++) send(CMD_DELTA, 8'($urandom_range(0, 255)));
        effective = 1'b1;
    endtask

    // one malformed or out-of-range construct; raised says the block has already flagged it
    task automatic inject_fault(output bit raised);
        string      seps;
        logic [7:0] b;
        int         len;
        int         off;
        seps   = $sformatf("%c%c%c%c%cZ", CH_COLON, CH_COMMA, CH_ADD, CH_COPY, CH_NL);
        raised = 1'b1;
        n_fault++;
        case ($urandom_range(0, 8))
            0: begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_ADD || b == CH_COPY || b == CH_NL) b = "Z";
                send(CMD_DELTA, b);
            end
            1: begin
                send(CMD_DELTA, CH_NL);
                send(CMD_DELTA, CH_NL);
            end
            2: begin
                send(CMD_DELTA, $urandom_range(0, 1) ? CH_ADD : CH_COPY);
                send(CMD_DELTA, seps[$urandom_range(0, seps.len() - 1)]);
            end
            3: begin
                if ($urandom_range(0, 1))
                    send_text($sformatf("%c%0d%c", CH_ADD, $urandom_range(0, 9), CH_COMMA));
                else
                    send_text($sformatf("%c%0d%c", CH_COPY, $urandom_range(0, 9), CH_COLON));
            end
            4: begin
                len = $urandom_range(0, 3) == 0 ? 99999999 : $urandom_range(64, 200);
                send_text($sformatf("%c%0d%c0", CH_COPY, len, CH_COMMA));
                if ($urandom_range(0, 1)) send(CMD_DELTA, CH_NL);
                else raised = 1'b0;
            end
            5: begin
                len = $urandom_range(1, 8);
                off = old_bytes - len + 1 + $urandom_range(0, 20);
                if (off < 0) off = 0;
                if ($urandom_range(0, 3) == 0) off = 9999999;
                send_text($sformatf("%c%0d%c%0d", CH_COPY, len, CH_COMMA, off));
                if ($urandom_range(0, 1)) send(CMD_DELTA, $urandom_range(0, 1) ? CH_NL : CH_ADD);
                else raised = 1'b0;
            end
            6: begin
                len = $urandom_range(1, 20);
                send_text($sformatf("%c%0d%c", CH_ADD, len, CH_COLON));
                send_literal($urandom_range(0, len - 1));
                raised = 1'b0;
            end
            7: begin
                case ($urandom_range(0, 4))
                    0: send(CMD_DELTA, CH_ADD);
                    1: send_text($sformatf("%c%0d", CH_ADD, $urandom_range(0, 99)));
                    2: send(CMD_DELTA, CH_COPY);
                    3: send_text($sformatf("%c%0d", CH_COPY, $urandom_range(0, 99)));
                    default: send_text($sformatf("%c%0d%c", CH_COPY, $urandom_range(0, 9),
                                                 CH_COMMA));
                endcase
                raised = 1'b0;
            end
            default: begin
                send_text($sformatf("%c%0d%c", CH_COPY, $urandom_range(0, 9), CH_COMMA));
                send(CMD_DELTA, seps[$urandom_range(0, seps.len() - 1)]);
            end
        endcase
    endtask

    // a delta file: a few well-formed commands, sometimes one broken one, then the end request
    task automatic run_frame();
        int ncmd;
        int fault_at;
        int len;
        int off;
        int cap;
        bit raised;
        if ($urandom_range(0, 2) == 0) load_random($urandom_range(1, 24));
        if ($urandom_range(0, 19) == 0) begin
            effective = 1'b0;
            send(CMD_SPARE, 8'($urandom_range(0, 255)));
            effective = 1'b1;
        end
        ncmd     = $urandom_range(0, 4);
        fault_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ncmd) : -1;
        for (int k = 0; k <= ncmd; k++) begin
            if (k == fault_at) begin
                inject_fault(raised);
                if (raised) send_noise($urandom_range(0, 5));
                break;
            end
            if (k == ncmd) break;
            if ($urandom_range(0, 1)) send(CMD_DELTA, CH_NL);
            if ($urandom_range(0, 1)) begin
                n_literal++;
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
                send_text($sformatf("%c%0d%c", CH_ADD, len, CH_COLON));
                send_literal(len);
            end else begin
                n_copy++;
                cap = (old_bytes < MAX_COPY) ? old_bytes : MAX_COPY;
                if ($urandom_range(0, 1))
                    len = $urandom_range(0, (cap < 8) ? cap : 8);
                else
                    len = $urandom_range(0, cap);
                off = $urandom_range(0, old_bytes - len);
                if ($urandom_range(0, 7) == 0)
                    send_text($sformatf("%c00%0d%c0%0d", CH_COPY, len, CH_COMMA, off));
                else
                    send_text($sformatf("%c%0d%c%0d", CH_COPY, len, CH_COMMA, off));
            end
        end
        send(CMD_END, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, double newline, edge copies, flush then unfinished command
        send(CMD_LOAD, 8'h00);
        send(CMD_LOAD, 8'hFF);
        send(CMD_LOAD, 8'h80);
        send(CMD_LOAD, 8'h7F);
        send(CMD_DELTA, CH_NL);
        send(CMD_DELTA, CH_NL);
        send(CMD_DELTA, CH_ADD);
        send(CMD_END, 8'h00);
        send_text($sformatf("%c2%c2%c", CH_COPY, CH_COMMA, CH_ADD));
        send(CMD_END, 8'hFF);
        send(CMD_SPARE, 8'hFF);
        send_text($sformatf("%c%c1%c0%c%c0%c4", CH_NL, CH_COPY, CH_COMMA, CH_NL, CH_COPY,
                            CH_COMMA));
        send(CMD_END, 8'h55);

        rand_items = 0;
        while (rand_items < RANDOM_ITEMS) begin
            idle_en = ($urandom_range(0, 3) != 0);
            run_frame();
        end

        // closing part without idling: saturated numbers, copies at the top of the loaded data
        idle_en = 1'b0;
        send_text($sformatf("%c70000%c", CH_ADD, CH_COLON));
        send_literal(3);
        send(CMD_END, 8'h00);
        send_text($sformatf("%c99999%c1", CH_COPY, CH_COMMA));
        send(CMD_END, 8'h00);
        while (old_bytes < MAX_COPY) send(CMD_LOAD, 8'($urandom_range(0, 255)));
        load_random(4);
        send_text($sformatf("%c63%c%0d%c%c1%c%0d", CH_COPY, CH_COMMA, old_bytes - MAX_COPY,
                            CH_NL, CH_COPY, CH_COMMA, old_bytes - 1));
        send_text($sformatf("%c1%c", CH_ADD, CH_COLON));
        send(CMD_DELTA, 8'hFF);
        send_text($sformatf("%c1%c%0d", CH_COPY, CH_COMMA, old_bytes));
        send(CMD_END, 8'h00);
        send_text($sformatf("%c1%c99999999", CH_COPY, CH_COMMA));
        send(CMD_END, 8'h00);

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d loads, %0d delta bytes, %0d ends; %0d copies, %0d literals, %0d faults.",
                 n_load, n_delta, n_end, n_copy, n_literal, n_fault);
        $display("Checked %0d results against the prediction; old-file store reached %0d bytes.",
                 results_checked, old_bytes);
        if (mismatches == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
